/* sv/png_stored_rgb_encoder_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the PNG stored RGB encoder
// ----------------------------------------------------------------------------
`ifndef PNG_STORED_RGB_ENCODER_DEFINES_SVH
`define PNG_STORED_RGB_ENCODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PSE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/pse_pkg.sv */
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and functions of the PNG stored RGB encoder.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [15:0] BLOCK_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_RAW,
        ST_BLK,
        ST_TRAIL
    } emit_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } q_out_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] adler_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= ADLER_MOD) begin
            s = s - ADLER_MOD;
        end
        return s[15:0];
    endfunction

endpackage

/* sv/png_stored_rgb_encoder.sv */
// ----------------------------------------------------------------------------
// png_stored_rgb_encoder
// Turns raster-order RGB bytes into a complete PNG file with stored blocks.
// ----------------------------------------------------------------------------
// Feed pixel bytes R,G,B per pixel, rows top to bottom, on s_pixel_byte with
// s_valid/s_ready. The PNG file comes out one byte per request on m_out_byte
// with m_valid/m_ready; m_last marks the final byte of the IEND CRC.
// Set image_width (index 0) and image_height (index 1) through cfg_wr_en,
// cfg_index and cfg_wdata while the block is idle; a zero is taken as one.
// The first pixel byte of an image starts 43 header bytes; after them come
// the block header, the row's filter byte and then the pixel byte itself.
// Every pixel byte passes through the queue and the output register.
// Throughput is one output byte per cycle while the receiver takes them and
// pixel bytes are queued: a pixel byte is taken per output byte except for
// each row's filter byte, five block header bytes per 65535 data bytes, the
// header and 20-byte trailer, as the emitter puts out one byte per cycle. A
// small input queue lets the source keep sending while the receiver stalls; a stalled
// receiver holds the output byte and, once the queue fills, s_ready drops.
// Reset returns to idle, clears the queue and sets both sizes to one.
// ----------------------------------------------------------------------------
module png_stored_rgb_encoder
    import pse_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_pixel_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_last
);

    logic [15:0] width_reg, height_reg;
    q_out_t      q;
    logic        pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_wdata;
                CFG_HEIGHT: height_reg <= cfg_wdata;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    pse_byte_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_pixel_byte),
        .q       (q),
        .pop     (pop)
    );

    pse_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .q          (q),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule

/* sv/pse_byte_queue.sv */
// ----------------------------------------------------------------------------
// pse_byte_queue
// Front end: takes pixel byte requests and holds them for the emitter.
// ----------------------------------------------------------------------------
module pse_byte_queue
    import pse_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data,
    output q_out_t     q,
    input  logic       pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [7:0]       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;

    assign s_ready = (cnt_reg != CNT_FULL);
    assign push    = s_valid && s_ready;
    assign q.valid = (cnt_reg != '0);
    assign q.data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= s_data;
        end
    end

endmodule

/* sv/pse_emitter.sv */
// ----------------------------------------------------------------------------
// pse_emitter
// Back end: sequences the PNG stream, wraps queued pixel bytes in stored
// deflate blocks and keeps the CRC and Adler sums.
// ----------------------------------------------------------------------------
`include "png_stored_rgb_encoder_defines.svh"

module pse_emitter
    import pse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] cfg_width,
    input  logic [15:0] cfg_height,
    input  q_out_t      q,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);

    emit_state_t state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [31:0] crc_reg;
    logic [15:0] adl_lo_reg, adl_hi_reg;
    logic [33:0] pos_reg;
    logic [17:0] row_reg;
    logic [15:0] blk_left_reg;
    logic [15:0] blen_reg;
    logic        filt_pend_reg;
    logic [15:0] use_w_reg, use_h_reg;
    logic [17:0] three_w_reg;
    logic [33:0] raw_total_reg;
    logic [18:0] blocks_reg;
    logic [31:0] idat_len_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    logic        adv, emit, fire, crc_upd, crc_init, raw_byte, pixel, pop_c, emit_last;
    logic [7:0]  emit_byte;
    logic [33:0] remain;
    logic        fits;
    logic [15:0] blen_now;
    logic [31:0] crc_x;
    logic        last_pix, start;
    logic [15:0] adl_lo_new;

    logic [34:0] y;
    logic [18:0] hi;
    logic [19:0] s;
    logic [16:0] t;

    assign adv      = !out_valid_reg || m_ready;
    assign remain   = raw_total_reg - pos_reg;
    assign fits     = (remain <= {18'd0, BLOCK_MAX});
    assign blen_now = fits ? remain[15:0] : BLOCK_MAX;
    assign crc_x    = ~crc_reg;
    assign last_pix = ((pos_reg + 34'd1) == raw_total_reg);
    assign start    = (state_reg == ST_IDLE) && q.valid;
    assign fire     = emit && adv;
    assign pop      = pop_c && adv;

    // output decode
    always_comb begin
        emit      = 1'b0;
        emit_byte = 8'h00;
        emit_last = 1'b0;
        crc_upd   = 1'b0;
        crc_init  = 1'b0;
        raw_byte  = 1'b0;
        pixel     = 1'b0;
        pop_c     = 1'b0;
        case (state_reg)
            ST_HEAD: begin
                emit = 1'b1;
                case (step_reg)
                    6'd0:  emit_byte = 8'h89;
                    6'd1:  emit_byte = 8'h50;
                    6'd2:  emit_byte = 8'h4E;
                    6'd3:  emit_byte = 8'h47;
                    6'd4:  emit_byte = 8'h0D;
                    6'd5:  emit_byte = 8'h0A;
                    6'd6:  emit_byte = 8'h1A;
                    6'd7:  emit_byte = 8'h0A;
                    6'd11: emit_byte = 8'd13;
                    6'd12: emit_byte = 8'h49;
                    6'd13: emit_byte = 8'h48;
                    6'd14: emit_byte = 8'h44;
                    6'd15: emit_byte = 8'h52;
                    6'd18: emit_byte = use_w_reg[15:8];
                    6'd19: emit_byte = use_w_reg[7:0];
                    6'd22: emit_byte = use_h_reg[15:8];
                    6'd23: emit_byte = use_h_reg[7:0];
                    6'd24: emit_byte = 8'd8;
                    6'd25: emit_byte = 8'd2;
                    6'd29: emit_byte = crc_x[31:24];
                    6'd30: emit_byte = crc_x[23:16];
                    6'd31: emit_byte = crc_x[15:8];
                    6'd32: emit_byte = crc_x[7:0];
                    6'd33: emit_byte = idat_len_reg[31:24];
                    6'd34: emit_byte = idat_len_reg[23:16];
                    6'd35: emit_byte = idat_len_reg[15:8];
                    6'd36: emit_byte = idat_len_reg[7:0];
                    6'd37: emit_byte = 8'h49;
                    6'd38: emit_byte = 8'h44;
                    6'd39: emit_byte = 8'h41;
                    6'd40: emit_byte = 8'h54;
                    6'd41: emit_byte = 8'h78;
                    6'd42: emit_byte = 8'h01;
                    default: emit_byte = 8'h00;
                endcase
                crc_upd  = ((step_reg >= 6'd12) && (step_reg <= 6'd28)) || (step_reg >= 6'd37);
                crc_init = (step_reg == 6'd12) || (step_reg == 6'd37);
            end
            ST_RAW: begin
                // hold block header and filter byte until their pixel request is queued
                if (q.valid) begin
                    if (blk_left_reg == '0) begin
                        emit      = 1'b1;
                        emit_byte = {7'd0, fits};
                        crc_upd   = 1'b1;
                    end else if (filt_pend_reg) begin
                        emit     = 1'b1;
                        crc_upd  = 1'b1;
                        raw_byte = 1'b1;
                    end else begin
                        emit      = 1'b1;
                        emit_byte = q.data;
                        crc_upd   = 1'b1;
                        raw_byte  = 1'b1;
                        pixel     = 1'b1;
                        pop_c     = 1'b1;
                    end
                end
            end
            ST_BLK: begin
                emit    = 1'b1;
                crc_upd = 1'b1;
                case (step_reg[2:0])
                    3'd1:    emit_byte = blen_reg[7:0];
                    3'd2:    emit_byte = blen_reg[15:8];
                    3'd3:    emit_byte = ~blen_reg[7:0];
                    default: emit_byte = ~blen_reg[15:8];
                endcase
            end
            ST_TRAIL: begin
                emit = 1'b1;
                case (step_reg)
                    6'd0:  emit_byte = adl_hi_reg[15:8];
                    6'd1:  emit_byte = adl_hi_reg[7:0];
                    6'd2:  emit_byte = adl_lo_reg[15:8];
                    6'd3:  emit_byte = adl_lo_reg[7:0];
                    6'd4:  emit_byte = crc_x[31:24];
                    6'd5:  emit_byte = crc_x[23:16];
                    6'd6:  emit_byte = crc_x[15:8];
                    6'd7:  emit_byte = crc_x[7:0];
                    6'd12: emit_byte = 8'h49;
                    6'd13: emit_byte = 8'h45;
                    6'd14: emit_byte = 8'h4E;
                    6'd15: emit_byte = 8'h44;
                    6'd16: emit_byte = crc_x[31:24];
                    6'd17: emit_byte = crc_x[23:16];
                    6'd18: emit_byte = crc_x[15:8];
                    6'd19: emit_byte = crc_x[7:0];
                    default: emit_byte = 8'h00;
                endcase
                crc_upd   = (step_reg <= 6'd3) || ((step_reg >= 6'd12) && (step_reg <= 6'd15));
                crc_init  = (step_reg == 6'd12);
                emit_last = (step_reg == 6'd19);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q.valid) begin
                    state_next = ST_HEAD;
                    step_next  = '0;
                end
            end
            ST_HEAD: begin
                if (adv) begin
                    step_next = step_reg + 6'd1;
                    if (step_reg == 6'd42) begin
                        state_next = ST_RAW;
                    end
                end
            end
            ST_RAW: begin
                if (adv) begin
                    if ((blk_left_reg == '0) && q.valid) begin
                        state_next = ST_BLK;
                        step_next  = 6'd1;
                    end else if (pixel && last_pix) begin
                        state_next = ST_TRAIL;
                        step_next  = '0;
                    end
                end
            end
            ST_BLK: begin
                if (adv) begin
                    step_next = step_reg + 6'd1;
                    if (step_reg == 6'd4) begin
                        state_next = ST_RAW;
                    end
                end
            end
            ST_TRAIL: begin
                if (adv) begin
                    step_next = step_reg + 6'd1;
                    if (step_reg == 6'd19) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            use_w_reg     <= 16'd1;
            use_h_reg     <= 16'd1;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (adv) begin
                out_valid_reg <= emit;
            end
            if (start) begin
                use_w_reg <= (cfg_width == '0) ? 16'd1 : cfg_width;
                use_h_reg <= (cfg_height == '0) ? 16'd1 : cfg_height;
            end
        end
    end

    // size figures are registered in turn: three_w, raw_total, blocks, idat_len
    always_comb begin
        y  = {1'b0, raw_total_reg} + 35'd65534;
        hi = y[34:16];
        s  = {1'b0, hi} + {4'd0, y[15:0]};
        t  = {13'd0, s[19:16]} + {1'b0, s[15:0]};
    end

    always_ff @(posedge aclk) begin
        three_w_reg   <= {1'b0, use_w_reg, 1'b0} + {2'b0, use_w_reg};
        raw_total_reg <= use_h_reg * (three_w_reg + 18'd1);
        blocks_reg    <= hi + {15'd0, s[19:16]} + {18'd0, (t >= 17'd65535)};
        idat_len_reg  <= 32'(raw_total_reg + 34'd6 + {13'd0, blocks_reg, 2'b0}
                         + {15'd0, blocks_reg});
    end

    assign adl_lo_new = adler_add(adl_lo_reg, {8'd0, emit_byte});

    always_ff @(posedge aclk) begin
        if (start) begin
            adl_lo_reg    <= 16'd1;
            adl_hi_reg    <= '0;
            pos_reg       <= '0;
            row_reg       <= '0;
            blk_left_reg  <= '0;
            filt_pend_reg <= 1'b1;
        end
        if (fire && crc_upd) begin
            crc_reg <= crc_byte(crc_init ? ALL_ONES : crc_reg, emit_byte);
        end
        if (fire && raw_byte) begin
            adl_lo_reg   <= adl_lo_new;
            adl_hi_reg   <= adler_add(adl_hi_reg, adl_lo_new);
            pos_reg      <= pos_reg + 34'd1;
            blk_left_reg <= blk_left_reg - 16'd1;
            if (pixel) begin
                if ((row_reg + 18'd1) == three_w_reg) begin
                    row_reg       <= '0;
                    filt_pend_reg <= 1'b1;
                end else begin
                    row_reg <= row_reg + 18'd1;
                end
            end else begin
                filt_pend_reg <= 1'b0;
            end
        end
        // latch the block length on the BFINAL byte, arm the count after NLEN
        if (fire && (state_reg == ST_RAW) && (blk_left_reg == '0)) begin
            blen_reg <= blen_now;
        end
        if (fire && (state_reg == ST_BLK) && (step_reg == 6'd4)) begin
            blk_left_reg <= blen_reg;
        end
        if (fire) begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_last     = out_last_reg;

    `PSE_ASSERT_NOW(pop_only_raw, aclk, aresetn, pop, state_reg == ST_RAW, "pop outside data")
    `PSE_ASSERT_NOW(blocks_drained, aclk, aresetn, state_reg == ST_TRAIL, blk_left_reg == '0, "block not drained at trailer")
    `PSE_ASSERT_NOW(row_in_range, aclk, aresetn, state_reg == ST_RAW, row_reg < three_w_reg, "row count overran")
    `PSE_ASSERT_NEXT(last_ends_image, aclk, aresetn, fire && emit_last, state_reg == ST_IDLE, "last byte without return to idle")

endmodule

/* verif/tb_png_stored_rgb_encoder.sv */
// ----------------------------------------------------------------------------
// tb_png_stored_rgb_encoder
// Self-checking bench for the PNG stored RGB encoder.
// ----------------------------------------------------------------------------
// Pixel bytes go in over s_valid/s_ready. A behavioral PNG writer in this
// bench computes every output byte (signature, IHDR, stored blocks, Adler-32,
// CRCs, IEND). A checker process compares each byte and its last flag in
// order. Image sizes change between images, with random gaps and stalls on
// both sides.
// ----------------------------------------------------------------------------
module tb_png_stored_rgb_encoder;
    import pse_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_pixel_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_out_byte;
    logic                  m_last;

    png_stored_rgb_encoder i_dut (.*);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } file_byte_t;

    file_byte_t  file_q[$];
    int          n_errors;
    int          n_bytes_seen;
    int          n_pixels_sent;
    int          n_images;
    int          idle_pct;
    int          hold_off;

    // writer state
    logic [15:0] reg_w, reg_h;
    logic [31:0] w_use, h_use;
    logic [31:0] crc_acc;
    logic [15:0] ad_lo, ad_hi;
    longint      raw_sent, raw_total;
    longint      row_cnt;
    longint      blk_left;
    bit          in_image;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        c = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
        return c;
    endfunction

    task automatic emit(logic [7:0] b, logic l = 1'b0);
        file_q.insert(file_q.size(), file_byte_t'{b, l});
    endtask

    task automatic emit_crc(logic [7:0] b);
        crc_acc = crc_step(crc_acc, b);
        emit(b);
    endtask

    task automatic emit32(logic [31:0] v, logic l = 1'b0);
        emit(v[31:24]); emit(v[23:16]); emit(v[15:8]); emit(v[7:0], l);
    endtask

    task automatic emit32_crc(logic [31:0] v);
        emit_crc(v[31:24]); emit_crc(v[23:16]); emit_crc(v[15:8]); emit_crc(v[7:0]);
    endtask

    task automatic emit_type(logic [31:0] t);
        crc_acc = 32'hFFFFFFFF;
        emit32_crc(t);
    endtask

    task automatic emit_raw(logic [7:0] b);
        longint remain, blen;
        logic [31:0] s;
        if (blk_left == 0) begin
            remain = (raw_sent < raw_total) ? raw_total - raw_sent : 1;
            blen = remain > 65535 ? 65535 : remain;
            emit_crc(remain <= 65535 ? 8'd1 : 8'd0);
            emit_crc(blen[7:0]);
            emit_crc(blen[15:8]);
            emit_crc(~blen[7:0]);
            emit_crc(~blen[15:8]);
            blk_left = blen;
        end
        emit_crc(b);
        s = ad_lo + b;
        if (s >= 65521) s -= 65521;
        ad_lo = s[15:0];
        s = ad_hi + ad_lo;
        if (s >= 65521) s -= 65521;
        ad_hi = s[15:0];
        raw_sent++;
        blk_left--;
    endtask

    // expected file bytes caused by one pixel byte
    task automatic predict_file_bytes(logic [7:0] b);
        longint blocks;
        logic [31:0] idat_len;
        if (!in_image) begin
            w_use = reg_w ? reg_w : 1;
            h_use = reg_h ? reg_h : 1;
            raw_total = longint'(h_use) * (1 + 3 * longint'(w_use));
            blocks = (raw_total + 65534) / 65535;
            idat_len = 32'(2 + raw_total + 5 * blocks + 4);
            ad_lo = 16'd1; ad_hi = 16'd0; raw_sent = 0; row_cnt = 0; blk_left = 0;
            emit32(32'h89504E47);
            emit32(32'h0D0A1A0A);
            emit32(32'd13);
            emit_type(32'h49484452);
            emit32_crc(w_use);
            emit32_crc(h_use);
            emit_crc(8'd8); emit_crc(8'd2); emit_crc(8'd0); emit_crc(8'd0); emit_crc(8'd0);
            emit32(crc_acc ^ 32'hFFFFFFFF);
            emit32(idat_len);
            emit_type(32'h49444154);
            emit_crc(8'h78);
            emit_crc(8'h01);
            in_image = 1;
        end
        if (row_cnt == 0) emit_raw(8'h00);
        emit_raw(b);
        row_cnt++;
        if (row_cnt >= 3 * longint'(w_use)) row_cnt = 0;
        if (raw_sent >= raw_total) begin
            emit32_crc({ad_hi, ad_lo});
            emit32(crc_acc ^ 32'hFFFFFFFF);
            emit32(32'd0);
            emit_type(32'h49454E44);
            emit32(crc_acc ^ 32'hFFFFFFFF, 1'b1);
            in_image = 0;
            n_images++;
        end
    endtask

    // receiver: random stall, or a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // check each accepted file byte
    always @(posedge aclk) begin
        file_byte_t exp_b;
        if (aresetn && m_valid && m_ready) begin
            n_bytes_seen++;
            if (file_q.size() == 0) begin
                $error("unexpected byte %0h", m_out_byte);
                n_errors++;
            end else begin
                exp_b = file_q.pop_front();
                if (m_out_byte !== exp_b.data) begin
                    $error("out_byte expected %0h actual %0h", exp_b.data, m_out_byte);
                    n_errors++;
                end
                if (m_last !== exp_b.last) begin
                    $error("last expected %0b actual %0b", exp_b.last, m_last);
                    n_errors++;
                end
            end
        end
    end

    // valid stays up between back-to-back requests; drop it only to idle
    task automatic send_pixel(logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pixel_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_file_bytes(b);
        n_pixels_sent++;
    endtask

    task automatic wait_drained();
        while (file_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_size(logic [15:0] w, logic [15:0] h);
        wait_drained();
        cfg_wr_en <= 1'b1; cfg_index <= CFG_WIDTH;  cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= CFG_HEIGHT; cfg_wdata <= h;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        reg_w = w; reg_h = h;
    endtask

    task automatic send_image(bit random_data);
        longint n;
        n = 3 * longint'(reg_w ? reg_w : 1) * longint'(reg_h ? reg_h : 1);
        for (longint i = 0; i < n; i++)
            send_pixel(random_data ? 8'($urandom) : ((i % 2) ? 8'hFF : 8'h00));
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_size();
        send_image(0);
        send_image(1);
    endtask

    task automatic test_zero_sizes();
        set_size(16'd0, 16'd0);
        send_image(1);
        set_size(16'd2, 16'd0);
        send_image(1);
    endtask

    task automatic test_back_to_back();
        // no idling on either side for a whole image
        set_size(16'd9, 16'd6);
        idle_pct = 0;
        send_image(1);
        wait_drained();
        idle_pct = 29;
    endtask

    task automatic test_backpressure();
        set_size(16'd4, 16'd3);
        hold_off = 300;
        send_image(1);
        wait_drained();
    endtask

    task automatic test_size_change();
        set_size(16'd2, 16'd2);
        send_image(1);
        set_size(16'd7, 16'd2);
        send_image(1);
    endtask

    task automatic test_random_images();
        int sent0;
        sent0 = n_pixels_sent;
        while (n_pixels_sent - sent0 < 110) begin
            set_size(16'($urandom_range(1, 9)), 16'($urandom_range(1, 6)));
            idle_pct = ($urandom_range(3) == 0) ? 0 : 29;
            send_image(1);
        end
        idle_pct = 29;
    endtask

    initial begin
        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_index = CFG_WIDTH; cfg_wdata = '0;
        s_valid = 1'b0; s_pixel_byte = '0; hold_off = 0; idle_pct = 29;
        n_errors = 0; n_bytes_seen = 0; n_pixels_sent = 0; n_images = 0;
        reg_w = 16'd1; reg_h = 16'd1; in_image = 0; crc_acc = '1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_size();
        test_zero_sizes();
        test_backpressure();
        test_size_change();
        test_back_to_back();
        test_random_images();
        wait_drained();
        $display("Sent %0d pixel bytes in %0d images, checked %0d file bytes",
                 n_pixels_sent, n_images, n_bytes_seen);
        $display("Sizes covered: zero, one, small random, resized images, full stall and no-gap runs");
        if (n_errors == 0 && file_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/pse_pkg.sv
sv/pse_byte_queue.sv
sv/pse_emitter.sv
sv/png_stored_rgb_encoder.sv
verif/tb_png_stored_rgb_encoder.sv
